FILE: rtl/efr_pkg.sv
`default_nettype none
package efr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int GUARD_BITS    = 16;

  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;
  localparam logic signed [33:0] QUARTER_TURN = 34'sh0_4000_0000;
  localparam logic signed [33:0] HALF_TURN    = 34'sh0_8000_0000;

  localparam logic [1:0] FUNC_B2NED   = 2'd0;
  localparam logic [1:0] FUNC_NED2B   = 2'd1;
  localparam logic [1:0] FUNC_B2LEVEL = 2'd2;
  localparam logic [1:0] FUNC_PASS    = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // item traveling down the chain: vector in Q47.16 plus the angles still needed
  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] vz;
  } ctx_t;

  // what one rotation slot does with the item
  typedef struct packed {
    logic [1:0]         axis;
    logic               bypass;
    logic signed [33:0] ang;
  } job_t;

  function automatic logic [31:0] atan_q32(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // binary angle to 2^32-per-turn, optionally negated
  function automatic logic signed [33:0] ang_q32(input logic signed [15:0] a,
                                                 input logic neg);
    logic signed [33:0] t;
    t = {{2{a[15]}}, a, 16'h0000};
    return neg ? -t : t;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/efr_rotate.sv
`default_nettype none
// One axis rotation: pre-rotation, pipelined CORDIC, two-stage gain multiply.
module efr_rotate #(
  parameter int STAGES = efr_pkg::CORDIC_STAGES
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire efr_pkg::ctx_t in_ctx,
  input  wire efr_pkg::job_t in_job,
  output logic               out_valid,
  output efr_pkg::ctx_t      out_ctx
);

  localparam int NS = (STAGES > 32) ? 32 : STAGES;

  logic signed [63:0] a_r [0:NS];
  logic signed [63:0] b_r [0:NS];
  logic signed [33:0] z_r [0:NS];
  efr_pkg::ctx_t      ctx_r [0:NS];
  logic [1:0]         axis_r [0:NS];
  logic               byp_r [0:NS];
  logic               vld_r [0:NS];

  logic signed [63:0] a_sel, b_sel, a_nxt, b_nxt;
  logic signed [33:0] z_nxt;

  always_comb begin
    case (in_job.axis)
      efr_pkg::AXIS_X: begin a_sel = in_ctx.vy; b_sel = in_ctx.vz; end
      efr_pkg::AXIS_Y: begin a_sel = in_ctx.vz; b_sel = in_ctx.vx; end
      default:         begin a_sel = in_ctx.vx; b_sel = in_ctx.vy; end
    endcase
    a_nxt = a_sel;
    b_nxt = b_sel;
    z_nxt = in_job.ang;
    if (in_job.ang > efr_pkg::QUARTER_TURN) begin
      a_nxt = -a_sel; b_nxt = -b_sel; z_nxt = in_job.ang - efr_pkg::HALF_TURN;
    end else if (in_job.ang < -efr_pkg::QUARTER_TURN) begin
      a_nxt = -a_sel; b_nxt = -b_sel; z_nxt = in_job.ang + efr_pkg::HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
    if (en) begin
      a_r[0]    <= a_nxt;
      b_r[0]    <= b_nxt;
      z_r[0]    <= z_nxt;
      ctx_r[0]  <= in_ctx;
      axis_r[0] <= in_job.axis;
      byp_r[0]  <= in_job.bypass;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_cordic
    logic signed [63:0] as, bs;
    logic signed [33:0] at;
    assign as = a_r[k] >>> k;
    assign bs = b_r[k] >>> k;
    assign at = {2'b00, efr_pkg::atan_q32(5'(k))};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        if (z_r[k] >= 0) begin
          a_r[k+1] <= a_r[k] - bs;
          b_r[k+1] <= b_r[k] + as;
          z_r[k+1] <= z_r[k] - at;
        end else begin
          a_r[k+1] <= a_r[k] + bs;
          b_r[k+1] <= b_r[k] - as;
          z_r[k+1] <= z_r[k] + at;
        end
        ctx_r[k+1]  <= ctx_r[k];
        axis_r[k+1] <= axis_r[k];
        byp_r[k+1]  <= byp_r[k];
      end
    end
  end

  // gain: magnitude split at bit 32 into two partial products
  logic [63:0] ma, mb;
  assign ma = a_r[NS][63] ? 64'(-a_r[NS]) : 64'(a_r[NS]);
  assign mb = b_r[NS][63] ? 64'(-b_r[NS]) : 64'(b_r[NS]);

  logic        g_vld_r, g_nega_r, g_negb_r;
  logic [61:0] hia_r, hib_r;
  logic [63:0] loa_r, lob_r;
  efr_pkg::ctx_t g_ctx_r;
  logic [1:0]  g_axis_r;
  logic        g_byp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= vld_r[NS];
    end
    if (en) begin
      g_nega_r <= a_r[NS][63];
      g_negb_r <= b_r[NS][63];
      hia_r    <= ma[61:32] * efr_pkg::GAIN_Q32;
      hib_r    <= mb[61:32] * efr_pkg::GAIN_Q32;
      loa_r    <= ma[31:0] * efr_pkg::GAIN_Q32;
      lob_r    <= mb[31:0] * efr_pkg::GAIN_Q32;
      g_ctx_r  <= ctx_r[NS];
      g_axis_r <= axis_r[NS];
      g_byp_r  <= byp_r[NS];
    end
  end

  logic [64:0] loa_rnd, lob_rnd;
  logic [63:0] ra, rb;
  logic signed [63:0] fa, fb;
  efr_pkg::ctx_t ctx_nxt;

  always_comb begin
    loa_rnd = {1'b0, loa_r} + 65'h80000000;
    lob_rnd = {1'b0, lob_r} + 65'h80000000;
    ra = {2'b00, hia_r} + {31'd0, loa_rnd[64:32]};
    rb = {2'b00, hib_r} + {31'd0, lob_rnd[64:32]};
    fa = g_nega_r ? -$signed(ra) : $signed(ra);
    fb = g_negb_r ? -$signed(rb) : $signed(rb);
    ctx_nxt = g_ctx_r;
    if (!g_byp_r) begin
      case (g_axis_r)
        efr_pkg::AXIS_X: begin ctx_nxt.vy = fa; ctx_nxt.vz = fb; end
        efr_pkg::AXIS_Y: begin ctx_nxt.vz = fa; ctx_nxt.vx = fb; end
        default:         begin ctx_nxt.vx = fa; ctx_nxt.vy = fb; end
      endcase
    end
  end

  logic          o_vld_r;
  efr_pkg::ctx_t o_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= g_vld_r;
    end
    if (en) begin
      o_ctx_r <= ctx_nxt;
    end
  end

  assign out_valid = o_vld_r;
  assign out_ctx   = o_ctx_r;

endmodule
`default_nettype wire

FILE: rtl/euler_frame_rotation.sv
`default_nettype none
// Euler ZYX vector rotation. Fully pipelined: one vector per cycle while the
// output is not stalled. The pipe is three chained axis rotations, each a
// CORDIC stage per iteration (at most 32 iterations) plus pre-rotation and a
// two-stage gain multiply, and a final round/saturate stage. The whole pipe
// advances when the output register is empty or being taken; in_tready is that enable.
// func 0 body to NED, 1 NED to body, 2 body to level, 3 passes the vector.
module euler_frame_rotation #(
  parameter int CORDIC_STAGES = efr_pkg::CORDIC_STAGES
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [143:0] in_tdata,  // in_x, in_y, in_z, roll, pitch, yaw
  input  wire logic [1:0]   in_tuser,  // func
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata  // out_x, out_y, out_z
);

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  efr_pkg::ctx_t c0, c1, c2, c3;
  efr_pkg::job_t j0, j1, j2;
  logic v1, v2, v3;

  always_comb begin
    c0.func  = in_tuser;
    c0.vx    = {{16{in_tdata[31]}}, in_tdata[31:0], 16'h0000};
    c0.vy    = {{16{in_tdata[63]}}, in_tdata[63:32], 16'h0000};
    c0.vz    = {{16{in_tdata[95]}}, in_tdata[95:64], 16'h0000};
    c0.roll  = in_tdata[111:96];
    c0.pitch = in_tdata[127:112];
    c0.yaw   = in_tdata[143:128];
  end

  always_comb begin
    j0.axis = efr_pkg::AXIS_X; j0.bypass = 1'b0;
    j0.ang  = efr_pkg::ang_q32(c0.roll, 1'b0);
    case (c0.func)
      efr_pkg::FUNC_B2NED, efr_pkg::FUNC_B2LEVEL: ;
      efr_pkg::FUNC_NED2B: begin
        j0.axis = efr_pkg::AXIS_Z; j0.ang = efr_pkg::ang_q32(c0.yaw, 1'b1);
      end
      default: j0.bypass = 1'b1;
    endcase
    j1.axis   = efr_pkg::AXIS_Y;
    j1.bypass = (c1.func == efr_pkg::FUNC_PASS);
    j1.ang    = efr_pkg::ang_q32(c1.pitch, c1.func == efr_pkg::FUNC_NED2B);
    j2.axis = efr_pkg::AXIS_Z; j2.bypass = 1'b0;
    j2.ang  = efr_pkg::ang_q32(c2.yaw, 1'b0);
    case (c2.func)
      efr_pkg::FUNC_B2NED: ;
      efr_pkg::FUNC_NED2B: begin
        j2.axis = efr_pkg::AXIS_X; j2.ang = efr_pkg::ang_q32(c2.roll, 1'b1);
      end
      default: j2.bypass = 1'b1;
    endcase
  end

  efr_rotate #(.STAGES(CORDIC_STAGES)) u_rot0 (
    .clk, .rst_n, .en, .in_valid(in_tvalid), .in_ctx(c0), .in_job(j0),
    .out_valid(v1), .out_ctx(c1));
  efr_rotate #(.STAGES(CORDIC_STAGES)) u_rot1 (
    .clk, .rst_n, .en, .in_valid(v1), .in_ctx(c1), .in_job(j1),
    .out_valid(v2), .out_ctx(c2));
  efr_rotate #(.STAGES(CORDIC_STAGES)) u_rot2 (
    .clk, .rst_n, .en, .in_valid(v2), .in_ctx(c2), .in_job(j2),
    .out_valid(v3), .out_ctx(c3));

  function automatic logic [31:0] fin(input logic signed [63:0] v);
    logic signed [63:0] s;
    logic signed [47:0] r;
    s = v + 64'sd32768;
    r = s[63:16];
    if (r > 48'sh0000_7FFF_FFFF) return 32'h7FFFFFFF;
    if (r < -48'sh0000_8000_0000) return 32'h80000000;
    return r[31:0];
  endfunction

  logic        out_vld_r;
  logic [95:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v3;
    end
    if (en) begin
      out_data_r <= {fin(c3.vz), fin(c3.vy), fin(c3.vx)};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
